FILE: sv/ppit_pkg.sv
// Shared sizes, codes and word types for the polygon point-inside test.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ppit_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 24;

  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int PAIR_W = 2 * COORD_BITS;
  localparam int TERM_W = PAIR_W + 1;
  localparam int SUM_W  = TERM_W + IDX_W;
  localparam int AREA_W = 54;
  localparam int MAG_W  = (SUM_W > AREA_W) ? SUM_W : AREA_W;

  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_QUERY   = 1'b1;
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic                         command;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_vertex;
  } in_word_t;

  typedef struct packed {
    logic              kind;
    logic              inside_res;
    logic              clockwise;
    logic [AREA_W-1:0] twice_area;
    logic              error;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } vertex_t;

  // Query point travelling down the cell row.
  typedef struct packed {
    logic    valid;
    vertex_t pt;
  } token_t;

  // Running crossing parity handed from cell to cell.
  typedef struct packed {
    logic valid;
    logic par;
  } parity_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    vertex_t          pt;
  } cell_wr_t;

  // One shoelace term a.x*b.y - a.y*b.x.
  typedef struct packed {
    logic    valid;
    vertex_t a;
    vertex_t b;
  } term_req_t;

endpackage

`default_nettype wire

FILE: sv/ppit_cell.sv
// One cell of the vertex row: holds one vertex and tests the query point
// against the edge from its left neighbor's vertex. Depends on ppit_pkg.
`default_nettype none

module ppit_cell import ppit_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    wr_en,
  input  wire vertex_t wr_pt,
  input  wire logic    active,
  input  wire vertex_t prev_pt,
  output vertex_t      own_pt,
  input  wire token_t  tok_in,
  output token_t       tok_out,
  input  wire parity_t par_in,
  output parity_t      par_out
);

  vertex_t pt_r, pt_nxt;
  logic    tok_v_r;
  vertex_t tok_pt_r;

  logic                     s1_v_r;
  logic signed [DIFF_W-1:0] a_r, dy_r, c_r, e_r;
  logic signed [DIFF_W-1:0] a_nxt, dy_nxt, c_nxt, e_nxt;
  logic                     span_r, span_nxt, up_r, up_nxt;

  logic                     s2_v_r;
  logic signed [PROD_W-1:0] pad_r, pce_r, pad_nxt, pce_nxt;
  logic                     span2_r, up2_r;

  logic par_v_r, par_r, par_nxt, cross_hit;

  always_comb begin
    pt_nxt = wr_en ? wr_pt : pt_r;
    // The edge spans the query row when y lies in [low end, high end).
    span_nxt = active &&
               ((pt_r.y <= tok_pt_r.y && tok_pt_r.y < prev_pt.y) ||
                (prev_pt.y <= tok_pt_r.y && tok_pt_r.y < pt_r.y));
    up_nxt  = prev_pt.y > pt_r.y;
    a_nxt   = DIFF_W'(tok_pt_r.x) - DIFF_W'(pt_r.x);
    dy_nxt  = DIFF_W'(prev_pt.y)  - DIFF_W'(pt_r.y);
    c_nxt   = DIFF_W'(prev_pt.x)  - DIFF_W'(pt_r.x);
    e_nxt   = DIFF_W'(tok_pt_r.y) - DIFF_W'(pt_r.y);
    pad_nxt = PROD_W'(a_r) * PROD_W'(dy_r);
    pce_nxt = PROD_W'(c_r) * PROD_W'(e_r);
    // The sign of the y span decides which way the cross products compare.
    cross_hit = up2_r ? (pad_r < pce_r) : (pce_r < pad_r);
    par_nxt   = par_in.par ^ (span2_r && cross_hit);
  end

  always_ff @(posedge clk) begin
    pt_r     <= pt_nxt;
    tok_pt_r <= tok_in.pt;
    a_r      <= a_nxt;
    dy_r     <= dy_nxt;
    c_r      <= c_nxt;
    e_r      <= e_nxt;
    span_r   <= span_nxt;
    up_r     <= up_nxt;
    pad_r    <= pad_nxt;
    pce_r    <= pce_nxt;
    span2_r  <= span_r;
    up2_r    <= up_r;
    par_r    <= par_nxt;
    if (!rst_n) begin
      tok_v_r <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      par_v_r <= 1'b0;
    end else begin
      tok_v_r <= tok_in.valid;
      s1_v_r  <= tok_v_r;
      s2_v_r  <= s1_v_r;
      par_v_r <= s2_v_r;
    end
  end

  assign own_pt        = pt_r;
  assign tok_out.valid = tok_v_r;
  assign tok_out.pt    = tok_pt_r;
  assign par_out.valid = par_v_r;
  assign par_out.par   = par_r;

endmodule

`default_nettype wire

FILE: sv/ppit_chain.sv
// Row of MAX_VERTICES vertex cells; the query point moves one cell per cycle
// and the crossing parity follows it. Depends on ppit_pkg and ppit_cell.
`default_nettype none

module ppit_chain import ppit_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_wr_t         wr,
  input  wire logic [CNT_W-1:0] count,
  input  wire token_t           tok_in,
  input  wire vertex_t          close_pt,
  output vertex_t               first_pt,
  output parity_t               result
);

  vertex_t own [MAX_VERTICES];
  token_t  tok [MAX_VERTICES];
  parity_t par [MAX_VERTICES];
  parity_t par_seed;

  assign par_seed.valid = 1'b0;
  assign par_seed.par   = 1'b0;

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    logic    wr_en;
    logic    active;
    vertex_t prev_pt;
    token_t  tok_src;
    parity_t par_src;

    assign wr_en  = wr.valid && (wr.idx == IDX_W'(k));
    assign active = CNT_W'(k) < count;

    // Cell zero closes the ring against the last stored vertex.
    if (k == 0) begin : g_head
      assign prev_pt = close_pt;
      assign tok_src = tok_in;
      assign par_src = par_seed;
    end else begin : g_body
      assign prev_pt = own[k-1];
      assign tok_src = tok[k-1];
      assign par_src = par[k-1];
    end

    ppit_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_en),
      .wr_pt   (wr.pt),
      .active  (active),
      .prev_pt (prev_pt),
      .own_pt  (own[k]),
      .tok_in  (tok_src),
      .tok_out (tok[k]),
      .par_in  (par_src),
      .par_out (par[k])
    );
  end

  assign first_pt = own[0];
  assign result   = par[MAX_VERTICES-1];

endmodule

`default_nettype wire

FILE: sv/ppit_shoelace.sv
// Shoelace accumulator: one term a.x*b.y - a.y*b.x per request, through a
// product stage and a difference stage into the running sum. Uses ppit_pkg.
`default_nettype none

module ppit_shoelace import ppit_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              clr,
  input  wire term_req_t         req,
  output logic signed [SUM_W-1:0] sum,
  output logic                   busy
);

  logic                     v1_r, v2_r;
  logic signed [PAIR_W-1:0] p1_r, p2_r, p1_nxt, p2_nxt;
  logic signed [TERM_W-1:0] term_r, term_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;

  always_comb begin
    p1_nxt   = PAIR_W'(req.a.x) * PAIR_W'(req.b.y);
    p2_nxt   = PAIR_W'(req.a.y) * PAIR_W'(req.b.x);
    term_nxt = TERM_W'(p1_r) - TERM_W'(p2_r);
    if (clr) begin
      sum_nxt = '0;
    end else if (v2_r) begin
      sum_nxt = sum_r + SUM_W'(term_r);
    end else begin
      sum_nxt = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    term_r <= term_nxt;
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      sum_r <= '0;
    end else begin
      v1_r  <= req.valid;
      v2_r  <= v1_r;
      sum_r <= sum_nxt;
    end
  end

  assign sum  = sum_r;
  assign busy = v1_r || v2_r;

endmodule

`default_nettype wire

FILE: sv/polygon_point_inside_test.sv
// Polygon point-inside test: one word at a time. A closing vertex gives its
// report word once the shoelace pipeline has drained. A query answer waits for
// the point to walk the length of the cell row, one cell per cycle.
// Synchronous active-low reset clears count, sum and flags; vertex cells keep
// their contents. Depends on ppit_pkg, ppit_chain and ppit_shoelace.
`default_nettype none

module polygon_point_inside_test import ppit_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_DRAIN,
    ST_QUERY,
    ST_REPORT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              closed_r, closed_nxt;
  logic              ovf_r, ovf_nxt;
  vertex_t           last_pt_r, last_pt_nxt;
  logic [SUM_W-1:0]  mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic              rep_kind_r, rep_kind_nxt;
  logic              rep_inside_r, rep_inside_nxt;
  logic              rep_err_r, rep_err_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r, out_data_nxt;

  logic                    in_fire, is_load, store, clr;
  logic [CNT_W-1:0]        base_cnt;
  vertex_t                 in_pt, first_pt;
  cell_wr_t                wr;
  token_t                  tok_inj;
  parity_t                 chain_res;
  term_req_t               term;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        sum_u;
  logic                    sl_busy;
  logic [MAG_W-1:0]        mag_ext;
  logic [AREA_W-1:0]       area_sat;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign is_load  = in_fire && (in_data.command == CMD_LOAD);
  assign in_pt.x  = in_data.point_x;
  assign in_pt.y  = in_data.point_y;

  // A load after a closed polygon starts a new one from an empty store.
  assign base_cnt = closed_r ? '0 : count_r;
  assign store    = is_load && (base_cnt < CNT_W'(MAX_VERTICES));
  assign clr      = is_load && closed_r;

  assign wr.valid = store;
  assign wr.idx   = base_cnt[IDX_W-1:0];
  assign wr.pt    = in_pt;

  assign tok_inj.valid = in_fire && (in_data.command == CMD_QUERY) && closed_r;
  assign tok_inj.pt    = in_pt;

  always_comb begin
    if (state_r == ST_CLOSE) begin
      term.valid = 1'b1;
      term.a     = last_pt_r;
      term.b     = first_pt;
    end else begin
      term.valid = store && (base_cnt != '0);
      term.a     = last_pt_r;
      term.b     = in_pt;
    end
  end

  assign sum_u    = sum;
  assign mag_ext  = MAG_W'(mag_r);
  assign area_sat = (mag_ext > MAG_W'(AREA_MAX)) ? AREA_MAX : mag_ext[AREA_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    closed_nxt     = closed_r;
    ovf_nxt        = ovf_r;
    last_pt_nxt    = last_pt_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    rep_kind_nxt   = rep_kind_r;
    rep_inside_nxt = rep_inside_r;
    rep_err_nxt    = rep_err_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_data.command == CMD_QUERY)) begin
          rep_kind_nxt   = KIND_QUERY;
          rep_inside_nxt = 1'b0;
          mag_nxt        = '0;
          neg_nxt        = 1'b0;
          rep_err_nxt    = !closed_r;
          state_nxt      = closed_r ? ST_QUERY : ST_REPORT;
        end else if (is_load) begin
          closed_nxt = 1'b0;
          count_nxt  = store ? base_cnt + CNT_W'(1) : base_cnt;
          ovf_nxt    = (ovf_r && !closed_r) || !store;
          if (store) begin
            last_pt_nxt = in_pt;
          end
          if (in_data.last_vertex) begin
            state_nxt = ST_CLOSE;
          end
        end
      end
      ST_CLOSE: begin
        closed_nxt = 1'b1;
        state_nxt  = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sl_busy) begin
          neg_nxt        = sum_u[SUM_W-1];
          mag_nxt        = sum_u[SUM_W-1] ? (~sum_u + SUM_W'(1)) : sum_u;
          rep_kind_nxt   = KIND_REPORT;
          rep_inside_nxt = 1'b0;
          rep_err_nxt    = ovf_r;
          state_nxt      = ST_REPORT;
        end
      end
      ST_QUERY: begin
        if (chain_res.valid) begin
          rep_inside_nxt = chain_res.par;
          state_nxt      = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.kind       = rep_kind_r;
          out_data_nxt.inside_res = rep_inside_r;
          out_data_nxt.clockwise  = neg_r;
          out_data_nxt.twice_area = area_sat;
          out_data_nxt.error      = rep_err_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    last_pt_r    <= last_pt_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    rep_kind_r   <= rep_kind_nxt;
    rep_inside_r <= rep_inside_nxt;
    rep_err_r    <= rep_err_nxt;
    out_data_r   <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      closed_r    <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      closed_r    <= closed_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  ppit_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .count    (count_r),
    .tok_in   (tok_inj),
    .close_pt (last_pt_r),
    .first_pt (first_pt),
    .result   (chain_res)
  );

  ppit_shoelace u_shoelace (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr),
    .req   (term),
    .sum   (sum),
    .busy  (sl_busy)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: sv/ppit_checker.sv
// Port-level checks for the polygon point-inside test, bound to the top level.
// Depends on ppit_pkg.
`default_nettype none

module ppit_checker import ppit_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_word_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  // A vertex that does not close the polygon leaves the block ready.
  a_open_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command == CMD_LOAD && !in_data.last_vertex)
    |=> in_ready)
    else $error("input not ready after an open vertex load");

  // A closing vertex starts the report, so no word is taken next cycle.
  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command == CMD_LOAD && in_data.last_vertex)
    |=> !in_ready)
    else $error("input ready right after a closing vertex");

  // A query holds off the input until its answer is formed.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command == CMD_QUERY) |=> !in_ready)
    else $error("input ready right after a query");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result word dropped or changed while stalled");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind polygon_point_inside_test ppit_checker u_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for polygon_point_inside_test: vertex loads and point queries
// go in, report and answer words are checked against a predictor kept in this file.
// Depends on ppit_pkg and the polygon_point_inside_test RTL.
`timescale 1ns / 1ps

module tb_top;
  import ppit_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASE_ITEMS  = 430;

  localparam out_word_t NO_POLYGON_ANSWER =
    '{kind: KIND_QUERY, inside_res: 1'b0, clockwise: 1'b0, twice_area: '0, error: 1'b1};
  localparam out_word_t EMPTY_REPORT =
    '{kind: KIND_REPORT, inside_res: 1'b0, clockwise: 1'b0, twice_area: '0, error: 1'b0};
  localparam out_word_t OUTSIDE_ANSWER =
    '{kind: KIND_QUERY, inside_res: 1'b0, clockwise: 1'b0, twice_area: '0, error: 1'b0};

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t answer;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  // Predictor copy of the polygon.
  logic signed [COORD_BITS-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] poly_y [MAX_VERTICES];
  int unsigned poly_len;
  logic [63:0] poly_sum;
  bit          poly_closed;
  bit          poly_dropped;

  out_word_t answers_due [$];
  out_word_t want;
  stim_row_t rows [$];

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int failures;
  int items_sent;
  int cycle_count;

  polygon_point_inside_test u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[polygon_point_inside_test] ERROR");
      $finish;
    end
  end

  // Twice the signed area contribution of the edge a -> b.
  function automatic longint edge_area(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  // Advances the polygon state by one word; returns 1 when the word yields a result.
  function automatic bit predict_word(in_word_t w, output out_word_t ans);
    longint px, py, xi, yi, xj, yj, dy;
    int unsigned j;
    int unsigned tail;
    logic [63:0] mag;
    bit neg;
    bit par;
    bit crosses;
    ans = '0;
    px = $signed(w.point_x);
    py = $signed(w.point_y);
    if (w.command == CMD_QUERY) begin
      ans.kind = KIND_QUERY;
      ans.error = !poly_closed;
      par = 1'b0;
      if (poly_closed) begin
        for (int i = 0; i < poly_len; i++) begin
          j = (i == 0) ? poly_len - 1 : i - 1;
          xi = $signed(poly_x[i]);
          yi = $signed(poly_y[i]);
          xj = $signed(poly_x[j]);
          yj = $signed(poly_y[j]);
          // Edges with no y span never straddle the ray, so horizontal ones drop out.
          if ((yi <= py && py < yj) || (yj <= py && py < yi)) begin
            dy = yj - yi;
            crosses = (dy > 0) ? ((px - xi) * dy < (xj - xi) * (py - yi))
                               : ((xj - xi) * (py - yi) < (px - xi) * dy);
            par ^= crosses;
          end
        end
      end
      ans.inside_res = par;
      return 1'b1;
    end
    if (poly_closed) begin
      poly_closed = 1'b0;
      poly_len = 0;
      poly_sum = '0;
      poly_dropped = 1'b0;
    end
    if (poly_len < MAX_VERTICES) begin
      poly_x[poly_len] = w.point_x;
      poly_y[poly_len] = w.point_y;
      if (poly_len > 0)
        poly_sum += edge_area($signed(poly_x[poly_len-1]), $signed(poly_y[poly_len-1]), px, py);
      poly_len++;
    end else begin
      poly_dropped = 1'b1;
    end
    if (!w.last_vertex)
      return 1'b0;
    // A dropped closing vertex still closes from the last stored one.
    tail = poly_len - 1;
    poly_sum += edge_area($signed(poly_x[tail]), $signed(poly_y[tail]),
                          $signed(poly_x[0]), $signed(poly_y[0]));
    poly_closed = 1'b1;
    neg = poly_sum[63];
    mag = neg ? -poly_sum : poly_sum;
    if (mag > {{(64-AREA_W){1'b0}}, AREA_MAX})
      mag = {{(64-AREA_W){1'b0}}, AREA_MAX};
    ans.kind = KIND_REPORT;
    ans.clockwise = neg;
    ans.twice_area = mag[AREA_W-1:0];
    ans.error = poly_dropped;
    return 1'b1;
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord(int mode, int c);
    case (mode)
      0: return COORD_BITS'(c + (int'($urandom_range(0, 16)) - 8) * 256);
      1: return COORD_BITS'(c + int'($urandom_range(0, 8191)) - 4096);
      2: return COORD_BITS'($urandom);
      default: begin
        case ($urandom_range(5))
          0: return {1'b1, {(COORD_BITS-1){1'b0}}};
          1: return {1'b0, {(COORD_BITS-1){1'b1}}};
          2: return '0;
          3: return '1;
          4: return COORD_BITS'(1);
          default: return {1'b1, {(COORD_BITS-2){1'b0}}, 1'b1};
        endcase
      end
    endcase
  endfunction

  task automatic send_word(in_word_t w, bit typed, out_word_t typed_ans);
    out_word_t ans;
    bit has;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    has = predict_word(w, ans);
    if (typed)
      answers_due.push_back(typed_ans);
    else if (has)
      answers_due.push_back(ans);
    items_sent++;
  endtask

  task automatic add_row(logic cmd, int x, int y, logic last, bit typed, out_word_t ans);
    stim_row_t r;
    r.word.command = cmd;
    r.word.point_x = COORD_BITS'(x);
    r.word.point_y = COORD_BITS'(y);
    r.word.last_vertex = last;
    r.typed = typed;
    r.answer = ans;
    rows.push_back(r);
  endtask

  // The sender drops valid while it waits, so the last word is not taken again.
  task automatic wait_answers();
    in_valid <= 1'b0;
    while (answers_due.size() != 0)
      @(posedge clk);
  endtask

  // Random polygons with queries around them, plus broken loads and stray queries.
  task automatic run_phase(int idle_pct, int stall_pct, int quota);
    in_word_t w;
    int start, n, mode, cx, cy, nq, r, idx;
    bit open_end, mid_query;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < quota) begin
      r = $urandom_range(99);
      n = (r < 6) ? $urandom_range(1, 2) : (r < 10) ? $urandom_range(60, 70)
                                                    : $urandom_range(3, 12);
      mode = $urandom_range(3);
      cx = $urandom;
      cy = $urandom;
      open_end = ($urandom_range(99) < 6);
      mid_query = ($urandom_range(99) < 8);
      for (int k = 0; k < n; k++) begin
        w.command = CMD_LOAD;
        w.point_x = pick_coord(mode, cx);
        w.point_y = pick_coord(mode, cy);
        w.last_vertex = (k == n - 1) && !open_end;
        send_word(w, 1'b0, '0);
        if (mid_query && k == n / 2) begin
          w.command = CMD_QUERY;
          w.last_vertex = $urandom_range(1);
          send_word(w, 1'b0, '0);
        end
      end
      nq = $urandom_range(1, 6);
      for (int q = 0; q < nq; q++) begin
        w.command = CMD_QUERY;
        w.last_vertex = $urandom_range(1);
        case ($urandom_range(3))
          0, 1: begin
            w.point_x = pick_coord(mode, cx);
            w.point_y = pick_coord(mode, cy);
          end
          2: begin
            // Points sharing coordinates with stored vertices hit the boundary rules.
            idx = $urandom_range(poly_len - 1);
            w.point_x = poly_x[idx];
            idx = $urandom_range(poly_len - 1);
            w.point_y = poly_y[idx];
          end
          default: begin
            w.point_x = COORD_BITS'($urandom);
            w.point_y = COORD_BITS'($urandom);
          end
        endcase
        send_word(w, 1'b0, '0);
      end
    end
    wait_answers();
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        $error("result word with nothing expected: %p", out_data);
        failures++;
      end else begin
        want = answers_due.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_data.kind);
          failures++;
        end
        if (out_data.inside_res !== want.inside_res) begin
          $error("inside_res: expected %0d, actual %0d", want.inside_res, out_data.inside_res);
          failures++;
        end
        if (out_data.clockwise !== want.clockwise) begin
          $error("clockwise: expected %0d, actual %0d", want.clockwise, out_data.clockwise);
          failures++;
        end
        if (out_data.twice_area !== want.twice_area) begin
          $error("twice_area: expected %0d, actual %0d", want.twice_area, out_data.twice_area);
          failures++;
        end
        if (out_data.error !== want.error) begin
          $error("error: expected %0d, actual %0d", want.error, out_data.error);
          failures++;
        end
      end
    end
  end

  initial begin
    in_word_t w;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    failures = 0;
    items_sent = 0;
    cycle_count = 0;
    poly_len = 0;
    poly_sum = '0;
    poly_closed = 1'b0;
    poly_dropped = 1'b0;

    // Query with nothing loaded, then a triangle spanning the full coordinate range.
    add_row(CMD_QUERY, 0, 0, 1'b0, 1'b1, NO_POLYGON_ANSWER);
    add_row(CMD_LOAD, -8388608, -8388608, 1'b0, 1'b0, '0);
    add_row(CMD_LOAD, 8388607, -8388608, 1'b0, 1'b0, '0);
    add_row(CMD_LOAD, 8388607, 8388607, 1'b1, 1'b0, '0);
    add_row(CMD_QUERY, 8388606, -8388607, 1'b0, 1'b0, '0);
    add_row(CMD_QUERY, -8388608, 8388607, 1'b0, 1'b0, '0);
    add_row(CMD_QUERY, 8388607, 8388607, 1'b1, 1'b0, '0);
    // Clockwise square with queries on its horizontal and vertical edges.
    add_row(CMD_LOAD, 0, 0, 1'b0, 1'b0, '0);
    add_row(CMD_LOAD, 0, 2560, 1'b0, 1'b0, '0);
    add_row(CMD_LOAD, 2560, 2560, 1'b0, 1'b0, '0);
    add_row(CMD_LOAD, 2560, 0, 1'b1, 1'b0, '0);
    add_row(CMD_QUERY, 1280, 1280, 1'b0, 1'b0, '0);
    add_row(CMD_QUERY, 1280, 0, 1'b0, 1'b0, '0);
    add_row(CMD_QUERY, 1280, 2560, 1'b0, 1'b0, '0);
    add_row(CMD_QUERY, 0, 1280, 1'b0, 1'b0, '0);
    // Degenerate polygons: a single vertex, then a single segment.
    add_row(CMD_LOAD, 256, 256, 1'b1, 1'b1, EMPTY_REPORT);
    add_row(CMD_QUERY, 256, 256, 1'b0, 1'b1, OUTSIDE_ANSWER);
    add_row(CMD_LOAD, 0, 0, 1'b0, 1'b0, '0);
    add_row(CMD_LOAD, 512, 512, 1'b1, 1'b1, EMPTY_REPORT);
    add_row(CMD_QUERY, 256, 256, 1'b0, 1'b1, OUTSIDE_ANSWER);
    // A load after a closed polygon reopens it, so the query is refused.
    add_row(CMD_LOAD, -256, 0, 1'b0, 1'b0, '0);
    add_row(CMD_QUERY, 0, 0, 1'b0, 1'b1, NO_POLYGON_ANSWER);
    add_row(CMD_LOAD, 256, 0, 1'b0, 1'b0, '0);
    add_row(CMD_LOAD, 0, -256, 1'b1, 1'b0, '0);
    add_row(CMD_QUERY, 0, -1, 1'b0, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i])
      send_word(rows[i].word, rows[i].typed, rows[i].answer);
    wait_answers();

    run_phase(0, 0, PHASE_ITEMS);

    // Receiver holds off while queries keep coming, so the block backs up.
    w.command = CMD_LOAD;
    w.last_vertex = 1'b0;
    w.point_x = COORD_BITS'(-1024);
    w.point_y = COORD_BITS'(-1024);
    send_word(w, 1'b0, '0);
    w.point_x = COORD_BITS'(1024);
    send_word(w, 1'b0, '0);
    w.point_y = COORD_BITS'(1024);
    w.last_vertex = 1'b1;
    send_word(w, 1'b0, '0);
    hold_req = 1'b1;
    for (int q = 0; q < 24; q++) begin
      w.command = CMD_QUERY;
      w.point_x = COORD_BITS'(int'($urandom_range(0, 3072)) - 1536);
      w.point_y = COORD_BITS'(int'($urandom_range(0, 3072)) - 1536);
      w.last_vertex = $urandom_range(1);
      send_word(w, 1'b0, '0);
    end
    wait_answers();

    run_phase(84, 0, PHASE_ITEMS);
    run_phase(0, 84, PHASE_ITEMS);
    run_phase(32, 32, PHASE_ITEMS);

    in_valid <= 1'b0;
    wait_answers();
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("[polygon_point_inside_test] OK");
    end else begin
      $display("[polygon_point_inside_test] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ppit_pkg.sv
sv/ppit_cell.sv
sv/ppit_chain.sv
sv/ppit_shoelace.sv
sv/polygon_point_inside_test.sv
sv/ppit_checker.sv
tb/tb_top.sv
